/* rtl/pse_pkg.sv */
// Shared constants and controller/datapath interface types for the percentile select engine.
package pse_pkg;

    // Default store depth
    localparam int CAPACITY_DEF = 1024;

    // Field widths
    localparam int SAMPLE_W = 32;
    localparam int FRAC_W   = 16;
    localparam int NUM_FRAC = 4;
    localparam int SEL_W    = 2;

    // Fraction register indexes
    localparam logic [SEL_W-1:0] CFG_FRACTION_A = 2'd0;
    localparam logic [SEL_W-1:0] CFG_FRACTION_B = 2'd1;
    localparam logic [SEL_W-1:0] CFG_FRACTION_C = 2'd2;
    localparam logic [SEL_W-1:0] CFG_FRACTION_D = 2'd3;

    // Fraction reset values, unsigned Q0.16
    localparam logic [FRAC_W-1:0] FRAC_A_RST = 16'd16384;
    localparam logic [FRAC_W-1:0] FRAC_B_RST = 16'd32768;
    localparam logic [FRAC_W-1:0] FRAC_C_RST = 16'd58983;
    localparam logic [FRAC_W-1:0] FRAC_D_RST = 16'd62260;

    // Commands from controller to datapath
    typedef struct packed {
        logic store;       // accept an item into the store
        logic sort_start;  // set closed: start insertion sort
        logic key_rd;      // read entry i as the next key
        logic key_latch;   // capture key, read entry j-1
        logic cmp;         // compare/shift step
        logic place;       // drop key into entry 0
        logic sel_mul;     // fraction times count
        logic sel_rd;      // read entry at percentile index
        logic sel_load;    // load result register
        logic sel_next;    // result taken, advance
    } pse_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic sort_done;   // outer index reached count
        logic greater;     // entry being compared is above the key
        logic j_one;       // shift position is at entry 1
        logic k_last;      // fourth result of the set
    } pse_status_t;

endpackage

/* rtl/pse_ctrl.sv */
// Controller state machine: load, insertion sort and result sequencing.
module pse_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 final_sample,
    input  logic                 out_ready,
    input  pse_pkg::pse_status_t status,
    output pse_pkg::pse_cmd_t    cmd,
    output logic                 in_ready,
    output logic                 out_valid
);

    typedef enum logic [8:0] {
        ST_LOAD       = 9'b000000001,
        ST_SORT_KEY   = 9'b000000010,
        ST_SORT_LATCH = 9'b000000100,
        ST_SORT_CMP   = 9'b000001000,
        ST_SORT_PLACE = 9'b000010000,
        ST_SEL_MUL    = 9'b000100000,
        ST_SEL_RD     = 9'b001000000,
        ST_SEL_LOAD   = 9'b010000000,
        ST_SEL_HOLD   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.store = 1'b1;
                    if (final_sample)
                    begin
                        cmd.sort_start = 1'b1;
                        state_next     = ST_SORT_KEY;
                    end
                end
            end
            ST_SORT_KEY:
            begin
                if (status.sort_done)
                begin
                    state_next = ST_SEL_MUL;
                end
                else
                begin
                    cmd.key_rd = 1'b1;
                    state_next = ST_SORT_LATCH;
                end
            end
            ST_SORT_LATCH:
            begin
                cmd.key_latch = 1'b1;
                state_next    = ST_SORT_CMP;
            end
            ST_SORT_CMP:
            begin
                cmd.cmp = 1'b1;
                if (!status.greater)
                begin
                    state_next = ST_SORT_KEY;
                end
                else if (status.j_one)
                begin
                    state_next = ST_SORT_PLACE;
                end
            end
            ST_SORT_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = ST_SORT_KEY;
            end
            ST_SEL_MUL:
            begin
                cmd.sel_mul = 1'b1;
                state_next  = ST_SEL_RD;
            end
            ST_SEL_RD:
            begin
                cmd.sel_rd = 1'b1;
                state_next = ST_SEL_LOAD;
            end
            ST_SEL_LOAD:
            begin
                cmd.sel_load = 1'b1;
                state_next   = ST_SEL_HOLD;
            end
            ST_SEL_HOLD:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.sel_next = 1'b1;
                    state_next   = status.k_last ? ST_LOAD : ST_SEL_MUL;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

/* rtl/pse_dp.sv */
// Datapath: value store, sort counters, fraction registers and result register.
module pse_dp
#(
    parameter int CAPACITY = pse_pkg::CAPACITY_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  pse_pkg::pse_cmd_t                   cmd,
    output pse_pkg::pse_status_t                status,
    input  logic                                cfg_we,
    input  logic [pse_pkg::SEL_W-1:0]           cfg_index,
    input  logic [pse_pkg::FRAC_W-1:0]          cfg_data,
    input  logic signed [pse_pkg::SAMPLE_W-1:0] sample,
    output logic signed [pse_pkg::SAMPLE_W-1:0] picked_value,
    output logic [pse_pkg::SEL_W-1:0]           which_fraction,
    output logic                                dropped_any,
    output logic                                end_of_run
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = pse_pkg::FRAC_W + CW;
    localparam int DW = pse_pkg::SAMPLE_W;

    // Value store
    logic [DW-1:0] mem [CAPACITY];
    logic [DW-1:0] rdata_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;

    logic [CW-1:0] count_reg;
    logic          ovf_reg;
    logic [CW-1:0] i_reg;
    logic [AW-1:0] j_reg;
    logic [pse_pkg::SEL_W-1:0] k_reg;
    logic [DW-1:0] key_reg;
    logic [PW-1:0] prod_reg;
    logic [pse_pkg::FRAC_W-1:0] frac_reg [pse_pkg::NUM_FRAC];

    logic          full;
    logic          greater;
    logic [CW-1:0] idx_full;
    logic [CW-1:0] last_idx;
    logic [CW-1:0] idx_clamp;

    // Status
    assign full      = (count_reg == CW'(CAPACITY));
    assign greater   = $signed(rdata_reg) > $signed(key_reg);
    assign status.sort_done = (i_reg >= count_reg);
    assign status.greater   = greater;
    assign status.j_one     = (j_reg == AW'(1));
    assign status.k_last    = (k_reg == pse_pkg::SEL_W'(pse_pkg::NUM_FRAC - 1));

    // Percentile index, clamped to the last stored entry
    assign idx_full  = prod_reg[PW-1:pse_pkg::FRAC_W];
    assign last_idx  = count_reg - CW'(1);
    assign idx_clamp = (idx_full > last_idx) ? last_idx : idx_full;

    // Store address and write selection
    always_comb
    begin
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = key_reg;
        if (cmd.key_rd)
        begin
            rd_addr = i_reg[AW-1:0];
        end
        if (cmd.key_latch)
        begin
            rd_addr = i_reg[AW-1:0] - AW'(1);
        end
        if (cmd.sel_rd)
        begin
            rd_addr = idx_clamp[AW-1:0];
        end
        if (cmd.store && !full)
        begin
            wr_en   = 1'b1;
            wr_addr = count_reg[AW-1:0];
            wr_data = sample;
        end
        if (cmd.cmp)
        begin
            rd_addr = j_reg - AW'(2);
            wr_en   = 1'b1;
            wr_addr = j_reg;
            wr_data = greater ? rdata_reg : key_reg;
        end
        if (cmd.place)
        begin
            wr_en   = 1'b1;
            wr_addr = j_reg;
            wr_data = key_reg;
        end
    end

    // Store write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Store read port, registered
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[rd_addr];
    end

    // Fraction registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_reg[0] <= pse_pkg::FRAC_A_RST;
            frac_reg[1] <= pse_pkg::FRAC_B_RST;
            frac_reg[2] <= pse_pkg::FRAC_C_RST;
            frac_reg[3] <= pse_pkg::FRAC_D_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pse_pkg::CFG_FRACTION_A: frac_reg[0] <= cfg_data;
                pse_pkg::CFG_FRACTION_B: frac_reg[1] <= cfg_data;
                pse_pkg::CFG_FRACTION_C: frac_reg[2] <= cfg_data;
                pse_pkg::CFG_FRACTION_D: frac_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Set fill, sort indexes and result counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            if (cmd.store)
            begin
                if (full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + CW'(1);
                end
            end
            if (cmd.sort_start)
            begin
                i_reg <= CW'(1);
                k_reg <= '0;
            end
            if (cmd.key_latch)
            begin
                j_reg <= i_reg[AW-1:0];
            end
            if (cmd.cmp)
            begin
                if (greater)
                begin
                    j_reg <= j_reg - AW'(1);
                end
                else
                begin
                    i_reg <= i_reg + CW'(1);
                end
            end
            if (cmd.place)
            begin
                i_reg <= i_reg + CW'(1);
            end
            if (cmd.sel_next)
            begin
                if (status.k_last)
                begin
                    count_reg <= '0;
                    ovf_reg   <= 1'b0;
                end
                else
                begin
                    k_reg <= k_reg + pse_pkg::SEL_W'(1);
                end
            end
        end
    end

    // Key, product and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.key_latch)
        begin
            key_reg <= rdata_reg;
        end
        if (cmd.sel_mul)
        begin
            prod_reg <= PW'(frac_reg[k_reg]) * PW'(count_reg);
        end
        if (cmd.sel_load)
        begin
            picked_value   <= rdata_reg;
            which_fraction <= k_reg;
            dropped_any    <= ovf_reg;
            end_of_run     <= status.k_last;
        end
    end

endmodule

/* rtl/percentile_select_engine.sv */
// Load one item per cycle; after the last item, insertion sort then four results.
// Sort: key read, key latch and compare per value, plus a shift step per inversion;
// each result then passes through the multiply, read, load and hold states.
// Throughput: one item per cycle while loading; intake is closed during sort and output.
// Reset: fractions return to 0.25/0.5/0.9/0.95, set empty; store contents undefined.
module percentile_select_engine
#(
    parameter int CAPACITY = pse_pkg::CAPACITY_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pse_pkg::SEL_W-1:0]           cfg_index,
    input  logic [pse_pkg::FRAC_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [pse_pkg::SAMPLE_W-1:0] sample,
    input  logic                                final_sample,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [pse_pkg::SAMPLE_W-1:0] picked_value,
    output logic [pse_pkg::SEL_W-1:0]           which_fraction,
    output logic                                dropped_any,
    output logic                                end_of_run
);

    pse_pkg::pse_cmd_t    cmd;
    pse_pkg::pse_status_t status;

    // Controller
    pse_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .final_sample (final_sample),
        .out_ready    (out_ready),
        .status       (status),
        .cmd          (cmd),
        .in_ready     (in_ready),
        .out_valid    (out_valid)
    );

    // Datapath
    pse_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .sample         (sample),
        .picked_value   (picked_value),
        .which_fraction (which_fraction),
        .dropped_any    (dropped_any),
        .end_of_run     (end_of_run)
    );

    // Intake and result never open together
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("intake open while a result is pending");

    // Last result flag matches the fourth fraction
    a_end_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (end_of_run == (which_fraction == pse_pkg::CFG_FRACTION_D)))
        else $error("end_of_run disagrees with which_fraction");

    // Closing item stops intake
    a_close: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && final_sample) |=> !in_ready)
        else $error("intake stayed open after the final item");

    // Last result taken reopens intake
    a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && end_of_run) |=> in_ready)
        else $error("intake not reopened after the last result");

endmodule
